/* rtl/apgr_pkg.sv */
`timescale 1ns / 1ps
package apgr_pkg;

    localparam int PASS_W        = 16;
    localparam int IN_W          = 32;
    localparam int OUT_W         = 8;
    localparam int NUM_CH        = 3;
    localparam int THR_MAX_W     = 25;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_BITS_DEF  = 32;
    localparam logic [OUT_W-1:0] BYTE_MAX = 8'hFF;

    // Smallest q with q^5 * 255^11 >= k^11 * 2^(5*frac), i.e. ceil(2^frac * (k/255)^2.2).
    // Evaluated at elaboration only.
    function automatic logic [THR_MAX_W-1:0] gamma_thr(input int unsigned k,
                                                       input int unsigned frac);
        logic [255:0] rhs;
        logic [255:0] lo;
        logic [255:0] hi;
        logic [255:0] mid;
        logic [255:0] p;
        int unsigned  i;
        rhs = 256'(1);
        for (i = 0; i < 11; i++) rhs = rhs * 256'(k);
        rhs = rhs << (5 * frac);
        lo = '0;
        hi = 256'(1) << frac;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            p = mid * mid * mid * mid * mid;
            for (i = 0; i < 11; i++) p = p * 256'(255);
            if (p >= rhs) begin
                hi = mid;
            end else begin
                lo = mid + 256'(1);
            end
        end
        return lo[THR_MAX_W-1:0];
    endfunction

endpackage

/* rtl/apgr_ifs.sv */
`timescale 1ns / 1ps
interface apgr_in_if import apgr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] sum_red;
    logic [IN_W-1:0] sum_green;
    logic [IN_W-1:0] sum_blue;

    modport source (output valid, sum_red, sum_green, sum_blue, input ready);
    modport sink   (input valid, sum_red, sum_green, sum_blue, output ready);
endinterface

interface apgr_out_if import apgr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

/* rtl/apgr_front.sv */
`timescale 1ns / 1ps
module apgr_front import apgr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_BITS  = SUM_BITS_DEF,
    parameter int ENT_W     = NUM_CH * (1 + PASS_W + FRAC_BITS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PASS_W-1:0] i_divisor,
    apgr_in_if.sink           i_pix,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ENT_W-1:0]  o_data
);

    localparam int EXT_W = (SUM_BITS > IN_W) ? SUM_BITS : IN_W;
    localparam int SX_W  = SUM_BITS + FRAC_BITS;
    localparam int CMP_W = SUM_BITS + PASS_W + FRAC_BITS;
    localparam int CH_W  = 1 + PASS_W + FRAC_BITS;

    logic                 r_valid;
    logic [ENT_W-1:0]     r_data;
    logic [ENT_W-1:0]     n_data;
    logic [IN_W-1:0]      w_sum [NUM_CH];

    assign w_sum[0] = i_pix.sum_red;
    assign w_sum[1] = i_pix.sum_green;
    assign w_sum[2] = i_pix.sum_blue;

    assign i_pix.ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    // Classify: average of 1.0 or more saturates; split every sum for the divider.
    always_comb begin
        logic [EXT_W-1:0]    ext;
        logic [SUM_BITS-1:0] s;
        logic [SX_W-1:0]     sx;
        logic                bright;
        n_data = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            ext    = EXT_W'(w_sum[c]);
            s      = ext[SUM_BITS-1:0];
            sx     = SX_W'(s);
            bright = CMP_W'(s) >= (CMP_W'(i_divisor) << FRAC_BITS);
            n_data[c*CH_W +: CH_W] = {bright, PASS_W'(sx >> FRAC_BITS), sx[FRAC_BITS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.valid && i_pix.ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_data <= n_data;
        end
    end

endmodule

/* rtl/apgr_queue.sv */
`timescale 1ns / 1ps
module apgr_queue import apgr_pkg::*; #(
    parameter int ENT_W = NUM_CH * (1 + PASS_W + FRAC_BITS_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [ENT_W-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [ENT_W-1:0] o_pop_data
);

    logic [ENT_W-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");

endmodule

/* rtl/apgr_back.sv */
`timescale 1ns / 1ps
module apgr_back import apgr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ENT_W     = NUM_CH * (1 + PASS_W + FRAC_BITS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PASS_W-1:0] i_divisor,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ENT_W-1:0]  i_data,
    apgr_out_if.source        o_pix
);

    localparam int F     = FRAC_BITS;
    localparam int CH_W  = 1 + PASS_W + F;
    localparam int THR_W = F + 1;
    localparam int NG    = OUT_W;

    logic w_en;

    // divider stages
    logic                 r_dv  [F];
    logic [PASS_W-1:0]    r_rem [F][NUM_CH];
    logic [F-1:0]         r_low [F][NUM_CH];
    logic [F-1:0]         r_q   [F][NUM_CH];
    logic [NUM_CH-1:0]    r_br  [F];

    // gamma search stages
    logic                 r_gv  [NG];
    logic [OUT_W-1:0]     r_acc [NG][NUM_CH];
    logic [F-1:0]         r_gq  [NG][NUM_CH];
    logic [NUM_CH-1:0]    r_gbr [NG];

    logic [THR_W-1:0]     w_thr [256];

    for (genvar k = 0; k < 256; k++) begin : g_thr
        assign w_thr[k] = THR_W'(gamma_thr(k, F));
    end

    // whole back pipeline advances together unless the last word is held
    assign w_en    = !r_gv[NG-1] || o_pix.ready;
    assign o_ready = w_en;

    assign o_pix.valid = r_gv[NG-1];
    assign o_pix.red   = r_acc[NG-1][0];
    assign o_pix.green = r_acc[NG-1][1];
    assign o_pix.blue  = r_acc[NG-1][2];

    for (genvar s = 0; s < F; s++) begin : g_div
        logic              v_in;
        logic [PASS_W-1:0] rem_in [NUM_CH];
        logic [F-1:0]      low_in [NUM_CH];
        logic [F-1:0]      q_in   [NUM_CH];
        logic [NUM_CH-1:0] br_in;

        if (s == 0) begin : g_src
            assign v_in = i_valid;
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign br_in[c]  = i_data[c*CH_W + CH_W - 1];
                assign rem_in[c] = i_data[c*CH_W + F +: PASS_W];
                assign low_in[c] = i_data[c*CH_W +: F];
                assign q_in[c]   = '0;
            end
        end else begin : g_src
            assign v_in  = r_dv[s-1];
            assign br_in = r_br[s-1];
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign rem_in[c] = r_rem[s-1][c];
                assign low_in[c] = r_low[s-1][c];
                assign q_in[c]   = r_q[s-1][c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (w_en) begin
                r_dv[s] <= v_in;
            end
        end

        // one quotient bit per stage: shift in next bit, subtract if it fits
        always_ff @(posedge i_clk) begin
            logic [PASS_W:0] rs;
            logic            ge;
            if (w_en) begin
                r_br[s] <= br_in;
                for (int c = 0; c < NUM_CH; c++) begin
                    rs = {rem_in[c], low_in[c][F-1]};
                    ge = rs >= {1'b0, i_divisor};
                    r_rem[s][c] <= ge ? PASS_W'(rs - {1'b0, i_divisor}) : rs[PASS_W-1:0];
                    r_low[s][c] <= low_in[c] << 1;
                    r_q[s][c]   <= {q_in[c][F-2:0], ge};
                end
            end
        end
    end

    for (genvar j = 0; j < NG; j++) begin : g_gam
        localparam int B = NG - 1 - j;
        logic              v_in;
        logic [OUT_W-1:0]  acc_in [NUM_CH];
        logic [F-1:0]      q_in   [NUM_CH];
        logic [NUM_CH-1:0] br_in;

        if (j == 0) begin : g_src
            assign v_in  = r_dv[F-1];
            assign br_in = r_br[F-1];
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign acc_in[c] = '0;
                assign q_in[c]   = r_q[F-1][c];
            end
        end else begin : g_src
            assign v_in  = r_gv[j-1];
            assign br_in = r_gbr[j-1];
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign acc_in[c] = r_acc[j-1][c];
                assign q_in[c]   = r_gq[j-1][c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_gv[j] <= 1'b0;
            end else if (w_en) begin
                r_gv[j] <= v_in;
            end
        end

        // binary search for the largest k whose threshold is at most q; bright channels force 255
        always_ff @(posedge i_clk) begin
            logic [OUT_W-1:0] cand;
            logic [OUT_W-1:0] nxt;
            if (w_en) begin
                r_gbr[j] <= br_in;
                for (int c = 0; c < NUM_CH; c++) begin
                    cand = acc_in[c] | (OUT_W'(1) << B);
                    nxt  = (w_thr[cand] <= THR_W'(q_in[c])) ? cand : acc_in[c];
                    if (j == NG - 1 && br_in[c]) begin
                        nxt = BYTE_MAX;
                    end
                    r_acc[j][c] <= nxt;
                    r_gq[j][c]  <= q_in[c];
                end
            end
        end
    end

    a_bright_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_gv[NG-2] && r_gbr[NG-2][0]) |=> (r_acc[NG-1][0] == BYTE_MAX))
        else $error("bright channel did not saturate");
    a_dim_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gv[NG-1] && !r_gbr[NG-1][1]) |-> (r_acc[NG-1][1] != BYTE_MAX))
        else $error("dim channel reached full scale");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gv[NG-1] && !o_pix.ready) |=> ($stable(r_dv[0]) && $stable(r_gv[0])))
        else $error("pipeline moved while output held");

endmodule

/* rtl/accumulated_pixel_gamma_resolve.sv */
`timescale 1ns / 1ps
// Accumulated pixel gamma resolve.
// Input channel i_pix carries one pixel's red, green and blue radiance sums
// (unsigned, FRAC_BITS fraction bits, low SUM_BITS bits used). Output channel
// o_pix carries the three gamma 1/2.2 bytes; alpha is implied 255.
// Both channels use valid/ready; a word moves when both are high.
// i_cfg_we with i_cfg_wdata loads the pass count; write it only while idle.
// A pass count of zero acts as one.
// Throughput: one pixel per clock while o_pix.ready stays high.
// An accepted pixel passes the front register and queue, then one
// divider stage per quotient bit, then eight stages of threshold search,
// before it shows as valid output.
// A two-entry queue splits the classifying front from the divider/search
// back end; when o_pix.ready is low with o_pix.valid high the back end holds,
// the queue fills, and then i_pix.ready drops.
// Reset (i_rst_n low at a clock edge) empties every stage and sets the
// pass count to one.
module accumulated_pixel_gamma_resolve import apgr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_BITS  = SUM_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PASS_W-1:0] i_cfg_wdata,
    apgr_in_if.sink           i_pix,
    apgr_out_if.source        o_pix
);

    localparam int ENT_W = NUM_CH * (1 + PASS_W + FRAC_BITS);

    logic [PASS_W-1:0] r_pass_count;
    logic [PASS_W-1:0] w_divisor;
    logic              w_f_valid;
    logic              w_f_ready;
    logic [ENT_W-1:0]  w_f_data;
    logic              w_b_valid;
    logic              w_b_ready;
    logic [ENT_W-1:0]  w_b_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_count <= PASS_W'(1);
        end else if (i_cfg_we) begin
            r_pass_count <= i_cfg_wdata;
        end
    end

    assign w_divisor = (r_pass_count == '0) ? PASS_W'(1) : r_pass_count;

    apgr_front #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_BITS  (SUM_BITS),
        .ENT_W     (ENT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_divisor (w_divisor),
        .i_pix     (i_pix),
        .o_valid   (w_f_valid),
        .i_ready   (w_f_ready),
        .o_data    (w_f_data)
    );

    apgr_queue #(
        .ENT_W (ENT_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  (w_f_data),
        .o_pop_valid  (w_b_valid),
        .i_pop_ready  (w_b_ready),
        .o_pop_data   (w_b_data)
    );

    apgr_back #(
        .FRAC_BITS (FRAC_BITS),
        .ENT_W     (ENT_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_divisor (w_divisor),
        .i_valid   (w_b_valid),
        .o_ready   (w_b_ready),
        .i_data    (w_b_data),
        .o_pix     (o_pix)
    );

endmodule
